@@ hw/rtl/assert_macros.svh @@
// assert_macros.svh: assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// checked only outside reset
`define ASSERT_RUN(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

@@ hw/rtl/dphs_pkg.sv @@
// dphs_pkg: types, codes and reset values for the double pulse haptic sequencer
// no dependencies
`timescale 1ns / 1ps

package dphs_pkg;

   localparam int TIMER_BITS_DEF = 26;
   localparam int REG_BITS       = 26;
   localparam int BYTE_BITS      = 8;
   localparam int IDX_BITS       = 3;

   localparam logic [REG_BITS-1:0]  WAIT_LIMIT_RST   = 26'd30000000;
   localparam logic [REG_BITS-1:0]  PULSE_LENGTH_RST = 26'd140000;
   localparam logic [REG_BITS-1:0]  GAP_LENGTH_RST   = 26'd180000;
   localparam logic [REG_BITS-1:0]  REASSERT_RST     = 26'd40000;
   localparam logic [BYTE_BITS-1:0] STRENGTH_RST     = 8'd36;
   localparam logic [BYTE_BITS-1:0] MOTOR_SEL_RST    = 8'h04;

   typedef enum logic [IDX_BITS-1:0] {
      REG_WAIT_LIMIT   = 3'd0,
      REG_PULSE_LENGTH = 3'd1,
      REG_GAP_LENGTH   = 3'd2,
      REG_REASSERT     = 3'd3,
      REG_STRENGTH     = 3'd4,
      REG_MOTOR_SEL    = 3'd5
   } reg_idx_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_WAIT   = 3'd1,
      PH_PULSE1 = 3'd2,
      PH_GAP    = 3'd3,
      PH_PULSE2 = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ACT_NONE  = 2'd0,
      ACT_DRIVE = 2'd1,
      ACT_STOP  = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      EV_NONE      = 3'd0,
      EV_QUEUED    = 3'd1,
      EV_STARTED   = 3'd2,
      EV_SKIPPED   = 3'd3,
      EV_COMPLETED = 3'd4
   } event_type;

   typedef struct packed {
      logic kind;
      logic partner_ready;
   } req_type;

   typedef struct packed {
      logic [1:0]           action;
      logic [BYTE_BITS-1:0] drive_mask;
      logic [BYTE_BITS-1:0] drive_strength;
      logic [2:0]           event_res;
      logic [2:0]           phase_now;
   } rsp_type;

   typedef struct packed {
      logic [IDX_BITS-1:0] index;
      logic [REG_BITS-1:0] wdata;
   } csr_type;

   typedef struct packed {
      logic [REG_BITS-1:0]  wait_limit;
      logic [REG_BITS-1:0]  pulse_length;
      logic [REG_BITS-1:0]  gap_length;
      logic [REG_BITS-1:0]  reassert_interval;
      logic [BYTE_BITS-1:0] pulse_strength;
      logic [BYTE_BITS-1:0] motor_select;
   } cfg_type;

endpackage

@@ hw/rtl/dphs_stream_if.sv @@
// dphs_stream_if: valid/ready channel carrying one beat of a given payload type
// depends on dphs_pkg for the default payload type
`timescale 1ns / 1ps

interface dphs_stream_if #(
   parameter type payload_type = dphs_pkg::req_type
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/dphs_csr_regs.sv @@
// dphs_csr_regs: configuration register file written through the csr channel
// depends on dphs_pkg and dphs_stream_if
`timescale 1ns / 1ps

module dphs_csr_regs (
   input  logic                clock,
   input  logic                reset,
   dphs_stream_if.sink         csr_chan,
   output dphs_pkg::cfg_type   cfg
);

   dphs_pkg::cfg_type cfg_ff;
   dphs_pkg::cfg_type cfg_in;
   logic              wr_en;

   assign csr_chan.ready = 1'b1;
   assign wr_en          = csr_chan.valid;
   assign cfg            = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (dphs_pkg::reg_idx_type'(csr_chan.data.index))
            dphs_pkg::REG_WAIT_LIMIT:   cfg_in.wait_limit = csr_chan.data.wdata;
            dphs_pkg::REG_PULSE_LENGTH: cfg_in.pulse_length = csr_chan.data.wdata;
            dphs_pkg::REG_GAP_LENGTH:   cfg_in.gap_length = csr_chan.data.wdata;
            dphs_pkg::REG_REASSERT:     cfg_in.reassert_interval = csr_chan.data.wdata;
            dphs_pkg::REG_STRENGTH:
               cfg_in.pulse_strength = csr_chan.data.wdata[dphs_pkg::BYTE_BITS-1:0];
            dphs_pkg::REG_MOTOR_SEL:
               cfg_in.motor_select = csr_chan.data.wdata[dphs_pkg::BYTE_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wait_limit        <= dphs_pkg::WAIT_LIMIT_RST;
         cfg_ff.pulse_length      <= dphs_pkg::PULSE_LENGTH_RST;
         cfg_ff.gap_length        <= dphs_pkg::GAP_LENGTH_RST;
         cfg_ff.reassert_interval <= dphs_pkg::REASSERT_RST;
         cfg_ff.pulse_strength    <= dphs_pkg::STRENGTH_RST;
         cfg_ff.motor_select      <= dphs_pkg::MOTOR_SEL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ hw/rtl/dphs_engine.sv @@
// dphs_engine: phase machine and down-counters, one item per advance strobe
// depends on dphs_pkg
`timescale 1ns / 1ps

module dphs_engine #(
   parameter int TIMER_BITS = dphs_pkg::TIMER_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  dphs_pkg::req_type item,
   input  dphs_pkg::cfg_type cfg,
   output dphs_pkg::rsp_type result
);

   dphs_pkg::phase_type   phase_ff, phase_in;
   logic [TIMER_BITS-1:0] wait_ff, wait_in;
   logic [TIMER_BITS-1:0] prem_ff, prem_in;
   logic [TIMER_BITS-1:0] reas_ff, reas_in;
   logic [TIMER_BITS-1:0] wait_dec, prem_dec, reas_dec;
   dphs_pkg::action_type  act;
   dphs_pkg::event_type   evt;

   assign wait_dec = (wait_ff != '0) ? wait_ff - TIMER_BITS'(1) : '0;
   assign prem_dec = (prem_ff != '0) ? prem_ff - TIMER_BITS'(1) : '0;
   assign reas_dec = (reas_ff != '0) ? reas_ff - TIMER_BITS'(1) : '0;

   always_comb begin
      phase_in = phase_ff;
      wait_in  = wait_ff;
      prem_in  = prem_ff;
      reas_in  = reas_ff;
      act      = dphs_pkg::ACT_NONE;
      evt      = dphs_pkg::EV_NONE;
      if (item.kind) begin
         phase_in = dphs_pkg::PH_WAIT;
         wait_in  = TIMER_BITS'(cfg.wait_limit);
         prem_in  = '0;
         reas_in  = '0;
         evt      = dphs_pkg::EV_QUEUED;
      end else if (phase_ff != dphs_pkg::PH_IDLE) begin
         wait_in = wait_dec;
         prem_in = prem_dec;
         reas_in = reas_dec;
         unique case (phase_ff)
            dphs_pkg::PH_WAIT: begin
               if (item.partner_ready) begin
                  phase_in = dphs_pkg::PH_PULSE1;
                  prem_in  = TIMER_BITS'(cfg.pulse_length);
                  reas_in  = TIMER_BITS'(cfg.reassert_interval);
                  act      = dphs_pkg::ACT_DRIVE;
                  evt      = dphs_pkg::EV_STARTED;
               end else if (wait_dec == '0) begin
                  phase_in = dphs_pkg::PH_IDLE;
                  evt      = dphs_pkg::EV_SKIPPED;
               end
            end
            dphs_pkg::PH_GAP: begin
               if (prem_dec == '0) begin
                  phase_in = dphs_pkg::PH_PULSE2;
                  prem_in  = TIMER_BITS'(cfg.pulse_length);
                  reas_in  = TIMER_BITS'(cfg.reassert_interval);
                  act      = dphs_pkg::ACT_DRIVE;
               end
            end
            dphs_pkg::PH_PULSE1, dphs_pkg::PH_PULSE2: begin
               if (prem_dec == '0) begin
                  act = dphs_pkg::ACT_STOP;
                  if (phase_ff == dphs_pkg::PH_PULSE1) begin
                     phase_in = dphs_pkg::PH_GAP;
                     prem_in  = TIMER_BITS'(cfg.gap_length);
                  end else begin
                     phase_in = dphs_pkg::PH_IDLE;
                     evt      = dphs_pkg::EV_COMPLETED;
                  end
               end else if (reas_dec == '0) begin
                  act     = dphs_pkg::ACT_DRIVE;
                  reas_in = TIMER_BITS'(cfg.reassert_interval);
               end
            end
            default: phase_in = dphs_pkg::PH_IDLE;
         endcase
      end
   end

   always_comb begin
      result.action         = act;
      result.drive_mask     = (act == dphs_pkg::ACT_DRIVE) ? cfg.motor_select : '0;
      result.drive_strength = (act == dphs_pkg::ACT_DRIVE) ? cfg.pulse_strength : '0;
      result.event_res      = evt;
      result.phase_now      = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dphs_pkg::PH_IDLE;
         wait_ff  <= '0;
         prem_ff  <= '0;
         reas_ff  <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         wait_ff  <= wait_in;
         prem_ff  <= prem_in;
         reas_ff  <= reas_in;
      end
   end

endmodule

@@ hw/rtl/double_pulse_haptic_sequencer_core.sv @@
// channel   | dir | payload                                        | beat
// req_chan  | in  | kind, partner_ready                            | one tick or start
// rsp_chan  | out | action, drive_mask, drive_strength, event_res, | one per req beat
//           |     | phase_now                                      |
// csr_chan  | in  | index, wdata                                   | one register write
//
// one req beat per cycle sustained while rsp_chan is ready; a req beat is held in the
// input register, then its result in the result register
// reset is synchronous: phase idle, counters zero, registers at defaults
// a stalled rsp_chan holds the result register and backs up into req_chan.ready
// csr_chan is always ready and takes effect on the next cycle
// top level of the double pulse haptic sequencer; depends on dphs_pkg,
// dphs_stream_if, dphs_csr_regs, dphs_engine and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module double_pulse_haptic_sequencer_core #(
   parameter int TIMER_BITS = dphs_pkg::TIMER_BITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   dphs_stream_if.sink    req_chan,
   dphs_stream_if.source  rsp_chan,
   dphs_stream_if.sink    csr_chan
);

   logic              s1_valid_ff, s1_valid_in;
   dphs_pkg::req_type s1_item_ff;
   logic              out_valid_ff, out_valid_in;
   dphs_pkg::rsp_type out_data_ff;
   dphs_pkg::rsp_type step_rsp;
   dphs_pkg::cfg_type cfg;
   logic              advance;
   logic              take;

   dphs_csr_regs u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   dphs_engine #(
      .TIMER_BITS (TIMER_BITS)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (s1_item_ff),
      .cfg     (cfg),
      .result  (step_rsp)
   );

   assign advance        = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_data_ff;

   always_comb begin
      s1_valid_in  = take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_item_ff <= req_chan.data;
      end
      if (advance) begin
         out_data_ff <= step_rsp;
      end
   end

   // checks
   `ASSERT_RUN(a_full_stall_blocks_req, clock, reset, (s1_valid_ff && out_valid_ff && !rsp_chan.ready) |-> !req_chan.ready, "req taken while both stages are stalled")
   `ASSERT_RUN(a_queued_enters_wait, clock, reset, (rsp_chan.valid && rsp_chan.data.event_res == dphs_pkg::EV_QUEUED) |-> (rsp_chan.data.phase_now == dphs_pkg::PH_WAIT), "queued event outside wait phase")
   `ASSERT_RUN(a_result_from_item, clock, reset, ($rose(out_valid_ff)) |-> $past(s1_valid_ff), "result with no item behind it")
   `ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_chan.valid, "rsp valid right after reset")

endmodule
